[hdl/mtc_pkg.sv]
// ----------------------------------------------------------------------------
// mtc_pkg: shared definitions for the MIDI timecode start/stop sync block
// Action, transport and run codes, register indexes, quarter frame type codes and the
// beat types passed between the top level and the decision core.
// ----------------------------------------------------------------------------
package mtc_pkg;

  localparam int ACTION_W    = 3;
  localparam int FRAME_W     = 7;
  localparam int TICKS_W     = 32;
  localparam int TIMEOUT_W   = 16;
  localparam int CMD_W       = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_CLOCK = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_FRAME = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CHECK = 3'd4;

  // transport_cmd codes
  localparam logic [CMD_W-1:0] XPORT_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] XPORT_START = 2'd1;
  localparam logic [CMD_W-1:0] XPORT_STOP  = 2'd2;

  // run_cmd codes
  localparam logic [CMD_W-1:0] RUN_NONE  = 2'd0;
  localparam logic [CMD_W-1:0] RUN_START = 2'd1;
  localparam logic [CMD_W-1:0] RUN_STOP  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd400;

  // quarter frame byte fields
  localparam logic [2:0] FRAME_TYPE_FIRST = 3'd0;
  localparam logic [2:0] FRAME_TYPE_LAST  = 3'd7;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [FRAME_W-1:0]  frame_byte;
    logic                seq_running;
    logic                ext_sync;
    logic [TICKS_W-1:0]  now_ticks;
  } item_t;

  typedef struct packed {
    logic             clock_pulse;
    logic [CMD_W-1:0] transport_cmd;
    logic [CMD_W-1:0] run_cmd;
  } result_t;

  typedef struct packed {
    logic                 sync_enable;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } cfg_t;

endpackage

[hdl/mtc_core.sv]
// ----------------------------------------------------------------------------
// mtc_core: event decision logic and timecode state
// Decodes one registered event into a result and updates the frame-ignore
// flag, the timecode-running flag and the last frame time stamp.
// ----------------------------------------------------------------------------
module mtc_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  mtc_pkg::item_t    item,
  input  mtc_pkg::cfg_t     cfg,
  output mtc_pkg::result_t  res
);

  logic                         ignore_frames_r, ignore_frames_nxt;
  logic                         tc_running_r, tc_running_nxt;
  logic [mtc_pkg::TICKS_W-1:0]  last_frame_r, last_frame_nxt;

  logic                         gate;
  logic [2:0]                   frame_type;
  logic [3:0]                   frame_value;
  logic [mtc_pkg::TICKS_W-1:0]  age;
  logic                         timed_out;

  assign gate        = cfg.sync_enable && item.ext_sync;
  assign frame_type  = item.frame_byte[6:4];
  assign frame_value = item.frame_byte[3:0];
  assign age         = item.now_ticks - last_frame_r;
  assign timed_out   = age > {{(mtc_pkg::TICKS_W-mtc_pkg::TIMEOUT_W){1'b0}}, cfg.timeout_ticks};

  always_comb begin
    ignore_frames_nxt = ignore_frames_r;
    tc_running_nxt    = tc_running_r;
    last_frame_nxt    = last_frame_r;
    res.clock_pulse   = 1'b0;
    res.transport_cmd = mtc_pkg::XPORT_NONE;
    res.run_cmd       = mtc_pkg::RUN_NONE;
    unique case (item.action)
      mtc_pkg::ACT_CLOCK: begin
        res.clock_pulse = gate;
      end
      mtc_pkg::ACT_START: begin
        if (gate) res.transport_cmd = mtc_pkg::XPORT_START;
      end
      mtc_pkg::ACT_STOP: begin
        if (gate) res.transport_cmd = mtc_pkg::XPORT_STOP;
      end
      mtc_pkg::ACT_FRAME: begin
        if (cfg.sync_enable) begin
          if (frame_type == mtc_pkg::FRAME_TYPE_FIRST) last_frame_nxt = item.now_ticks;
          // local play or external clock owns the transport: stamp only
          if (!item.seq_running && !item.ext_sync) begin
            priority if (item.frame_byte == '0) begin
              ignore_frames_nxt = 1'b0;
            end else if (ignore_frames_r) begin
              ignore_frames_nxt = 1'b1;
            end else if (frame_type != mtc_pkg::FRAME_TYPE_LAST) begin
              if (frame_value != 4'd0) ignore_frames_nxt = 1'b1;
            end else if (!item.frame_byte[0]) begin
              ignore_frames_nxt = 1'b1;
              tc_running_nxt    = 1'b1;
              last_frame_nxt    = item.now_ticks;
              res.run_cmd       = mtc_pkg::RUN_START;
            end
          end
        end
      end
      mtc_pkg::ACT_CHECK: begin
        if (tc_running_r) begin
          priority if (!item.seq_running) begin
            tc_running_nxt = 1'b0;
          end else if (timed_out) begin
            tc_running_nxt = 1'b0;
            res.run_cmd    = mtc_pkg::RUN_STOP;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ignore_frames_r <= 1'b1;
      tc_running_r    <= 1'b0;
      last_frame_r    <= '0;
    end else if (step) begin
      ignore_frames_r <= ignore_frames_nxt;
      tc_running_r    <= tc_running_nxt;
      last_frame_r    <= last_frame_nxt;
    end
  end

  a_start_sets_flags: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.run_cmd == mtc_pkg::RUN_START |=> tc_running_r && ignore_frames_r)
    else $error("timecode start did not set running and ignore flags");

  a_stop_clears_running: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.run_cmd == mtc_pkg::RUN_STOP |=> !tc_running_r)
    else $error("timecode stop left running flag set");

  a_clock_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.action == mtc_pkg::ACT_CLOCK |=>
      $stable(tc_running_r) && $stable(ignore_frames_r) && $stable(last_frame_r))
    else $error("clock beat changed timecode state");

  a_idle_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(tc_running_r) && $stable(ignore_frames_r) && $stable(last_frame_r))
    else $error("timecode state changed without a beat");

endmodule

[hdl/midi_timecode_start_stop_sync.sv]
// ----------------------------------------------------------------------------
// midi_timecode_start_stop_sync: MIDI clock, transport and timecode sync
// Input register, decision core and output register with valid/stall on both
// sides, plus the sync_enable and timeout_ticks configuration registers.
// ----------------------------------------------------------------------------
// A beat taken into the input register has its result written to the output
// register as it advances. Throughput: one beat per cycle; input and output
// registers each hold one beat, and the input stalls only when both are full
// and the output is stalled. Reset (rst_n low, synchronous): both stages
// empty, sync_enable 0, timeout_ticks 400, frames ignored, timecode not running.
module midi_timecode_start_stop_sync (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [mtc_pkg::ACTION_W-1:0]      in_action,
  input  logic [mtc_pkg::FRAME_W-1:0]       in_frame_byte,
  input  logic                              in_seq_running,
  input  logic                              in_ext_sync,
  input  logic [mtc_pkg::TICKS_W-1:0]       in_now_ticks,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_clock_pulse,
  output logic [mtc_pkg::CMD_W-1:0]         out_transport_cmd,
  output logic [mtc_pkg::CMD_W-1:0]         out_run_cmd,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mtc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mtc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic               s1_valid_r;
  mtc_pkg::item_t     s1_item_r;
  logic               out_valid_r;
  mtc_pkg::result_t   out_res_r;
  mtc_pkg::cfg_t      cfg_r;
  mtc_pkg::result_t   core_res;

  logic out_free;
  logic s1_adv;
  logic in_take;

  assign out_free  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_enable   <= 1'b0;
      cfg_r.timeout_ticks <= mtc_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mtc_pkg::REG_SYNC_ENABLE) cfg_r.sync_enable <= cfg_data[0];
      if (cfg_index == mtc_pkg::REG_TIMEOUT_TICKS)
        cfg_r.timeout_ticks <= cfg_data[mtc_pkg::TIMEOUT_W-1:0];
    end
  end

  // input stage: load a new beat whenever the held one moves on or none is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take || s1_adv) begin
      s1_valid_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.action      <= in_action;
      s1_item_r.frame_byte  <= in_frame_byte;
      s1_item_r.seq_running <= in_seq_running;
      s1_item_r.ext_sync    <= in_ext_sync;
      s1_item_r.now_ticks   <= in_now_ticks;
    end
  end

  mtc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (s1_adv),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) out_res_r <= core_res;
  end

  assign out_valid         = out_valid_r;
  assign out_clock_pulse   = out_res_r.clock_pulse;
  assign out_transport_cmd = out_res_r.transport_cmd;
  assign out_run_cmd       = out_res_r.run_cmd;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_item_r))
    else $error("held input beat lost or changed");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced beat did not reach the output register");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with room in the pipeline");

endmodule
